FILE: design/tme_pkg.sv
// Shared types and codes for the tape machine executor.
package tme_pkg;

   // Instruction codes carried on the request
   typedef enum logic [2:0] {
      FUNC_INC   = 3'd0,
      FUNC_DEC   = 3'd1,
      FUNC_LEFT  = 3'd2,
      FUNC_RIGHT = 3'd3,
      FUNC_INPUT = 3'd4,
      FUNC_OUTPUT = 3'd5,
      FUNC_JZ    = 3'd6,
      FUNC_JNZ   = 3'd7
   } func_type;

   // Fault codes returned with each result
   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_UNDER = 2'd1,
      FAULT_OVER  = 2'd2
   } fault_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Operation of the shared adder
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   // Control group from the sequencer to the shared adder
   typedef struct packed {
      alu_op_type op;
   } alu_ctl_type;

endpackage

FILE: design/tme_ram.sv
// Generic single write port, single read port RAM with registered read data.
module tme_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write when wr_en is high and read every cycle; read data is registered and lands in the next cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tme_alu.sv
// Shared add/subtract unit used for cell arithmetic and pointer moves.
module tme_alu #(
   parameter int WIDTH = 17
) (
   input  tme_pkg::alu_ctl_type ctl,
   input  logic [WIDTH-1:0]     opa,
   input  logic [WIDTH-1:0]     opb,
   output logic [WIDTH-1:0]     result
);
   import tme_pkg::*;

   // Add or subtract; with zero-extended operands the top bit flags a borrow
   always_comb begin
      case (ctl.op)
         ALU_ADD: result = opa + opb;
         ALU_SUB: result = opa - opb;
         default: result = opa + opb;
      endcase
   end

endmodule

FILE: design/tape_machine_executor.sv
// Top level of the tape machine executor: sequencer, tape RAM and result registers.
//
// Usage:
//   Drive req_func, req_operand and req_in_byte with start high; the request
//   is taken at a rising edge where start is high and busy is low.
//   busy stays high while a request executes and during the tape clear pass.
//   Each request gives one result on the rsp_ ports, marked by rsp_strobe
//   for exactly one cycle; the receiver cannot stall it.
// Timing:
//   The tape cell is read from the tape RAM in the accept cycle, then the
//   execute state updates the cell or pointer through the shared adder and
//   writes the cell back, or stores the input byte or next ip. The result
//   appears in the cycle after execute; no new request is taken during execute,
//   and the next can be taken in the cycle that result appears.
// Reset:
//   reset clears the cell pointer and instruction pointer, then sweeps the
//   tape to zero one cell a cycle, with busy high until every cell is cleared.
module tape_machine_executor #(
   parameter int TAPE_DEPTH = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_operand,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_strobe,
   output logic [15:0] rsp_next_ip,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_byte,
   output logic [15:0] rsp_out_repeat,
   output logic [1:0]  rsp_fault
);
   import tme_pkg::*;

   localparam int PW = $clog2(TAPE_DEPTH);
   localparam int UW = ((PW > 16) ? PW : 16) + 1;

   state_type   state_ff, state_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [15:0] ip_ff, ip_in;

   func_type    func_ff;
   logic [15:0] opnd_ff;
   logic [7:0]  inb_ff;

   logic        strobe_ff;
   logic [15:0] next_ip_ff, next_ip_in;
   logic        oval_ff, oval_in;
   logic [7:0]  obyte_ff, obyte_in;
   logic [15:0] orep_ff, orep_in;
   fault_type   fault_ff, fault_in;

   logic          wr_en;
   logic [PW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [7:0]    cell_rd;

   alu_ctl_type   alu_ctl;
   logic [UW-1:0] alu_a, alu_b, alu_r;

   logic accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Tape store
   tme_ram #(
      .WIDTH (8),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ptr_ff),
      .rd_data (cell_rd)
   );

   // Shared adder
   tme_alu #(
      .WIDTH (UW)
   ) u_alu (
      .ctl    (alu_ctl),
      .opa    (alu_a),
      .opb    (alu_b),
      .result (alu_r)
   );

   // Hold state, pointers and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         ptr_ff    <= '0;
         ip_ff     <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         ptr_ff    <= ptr_in;
         ip_ff     <= ip_in;
         strobe_ff <= (state_ff == ST_EXEC);
      end
   end

   // Capture the request and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         opnd_ff <= req_operand;
         inb_ff  <= req_in_byte;
      end
      if (state_ff == ST_EXEC) begin
         next_ip_ff <= next_ip_in;
         oval_ff    <= oval_in;
         obyte_ff   <= obyte_in;
         orep_ff    <= orep_in;
         fault_ff   <= fault_in;
      end
   end

   // Sequence the clear pass and each request's execute step
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      ptr_in     = ptr_ff;
      ip_in      = ip_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = cell_rd;
      alu_ctl.op = ALU_ADD;
      alu_a      = UW'(ptr_ff);
      alu_b      = UW'(opnd_ff);
      next_ip_in = ip_ff + 16'd1;
      oval_in    = 1'b0;
      obyte_in   = '0;
      orep_in    = '0;
      fault_in   = FAULT_NONE;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + PW'(1);
            if (clr_ff == PW'(TAPE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (func_ff)
               FUNC_INC: begin
                  alu_a   = UW'(cell_rd);
                  alu_b   = UW'(opnd_ff[7:0]);
                  wr_en   = 1'b1;
                  wr_data = alu_r[7:0];
               end
               FUNC_DEC: begin
                  alu_ctl.op = ALU_SUB;
                  alu_a      = UW'(cell_rd);
                  alu_b      = UW'(opnd_ff[7:0]);
                  wr_en      = 1'b1;
                  wr_data    = alu_r[7:0];
               end
               FUNC_LEFT: begin
                  alu_ctl.op = ALU_SUB;
                  if (alu_r[UW-1]) begin
                     fault_in = FAULT_UNDER;
                  end else begin
                     ptr_in = alu_r[PW-1:0];
                  end
               end
               FUNC_RIGHT: begin
                  if (alu_r >= UW'(TAPE_DEPTH)) begin
                     fault_in = FAULT_OVER;
                  end else begin
                     ptr_in = alu_r[PW-1:0];
                  end
               end
               FUNC_INPUT: begin
                  wr_en   = 1'b1;
                  wr_data = inb_ff;
               end
               FUNC_OUTPUT: begin
                  if (opnd_ff != 16'd0) begin
                     oval_in  = 1'b1;
                     obyte_in = cell_rd;
                     orep_in  = opnd_ff;
                  end
               end
               FUNC_JZ: begin
                  if (cell_rd == 8'd0) begin
                     next_ip_in = opnd_ff;
                  end
               end
               FUNC_JNZ: begin
                  if (cell_rd != 8'd0) begin
                     next_ip_in = opnd_ff;
                  end
               end
               default: begin
                  next_ip_in = ip_ff + 16'd1;
               end
            endcase
            ip_in = next_ip_in;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_next_ip    = next_ip_ff;
   assign rsp_out_valid  = oval_ff;
   assign rsp_out_byte   = obyte_ff;
   assign rsp_out_repeat = orep_ff;
   assign rsp_fault      = fault_ff;

endmodule
